// ===== rtl/ola_pkg.sv =====
// Package for the ordered list: command and status codes, field widths and shared types.
`default_nettype none
package ola_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int CMD_W   = 2;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 6;
    localparam int STS_W   = 2;
    localparam int COUNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL      = 2'd1;
    localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd2;
    localparam logic [STS_W-1:0] STS_RANGE     = 2'd3;

    // Token travelling along the row, one cell per cycle
    typedef struct packed {
        logic              tok;
        logic              fnd;
        logic [WORD_W-1:0] dat;
    } t_wave;

    // Controls broadcast to every cell
    typedef struct packed {
        logic               rm;
        logic               wr;
        logic [WORD_W-1:0]  value;
        logic [INDEX_W-1:0] index;
    } t_bcast;

endpackage
`default_nettype wire

// ===== rtl/ordered_list_append_remove.sv =====
// Top level of the ordered list: command control and the row of cells.
//
// Dense ordered list of up to CAPACITY 32-bit words. A command is taken when
// start is high and busy is low. For append and the unused command code
// o_valid pulses in the cycle after the transfer. A read outside the count
// also answers in the cycle after. A read in range and every remove send a
// token down the row of cells, one cell per cycle, from r_launch through each
// cell's wave register into o_valid, with busy high meanwhile; a remove shifts
// the later entries down as the token passes. Each result is shown for exactly
// one cycle with o_valid and must be taken then. No clearing pass after reset.
`default_nettype none
module ordered_list_append_remove #(
    parameter int CAPACITY = ola_pkg::CAPACITY_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire [ola_pkg::CMD_W-1:0]      i_cmd,
    input  wire [ola_pkg::WORD_W-1:0]     i_value,
    input  wire [ola_pkg::INDEX_W-1:0]    i_index,
    output logic                          o_valid,
    output logic [ola_pkg::STS_W-1:0]     o_status,
    output logic [ola_pkg::WORD_W-1:0]    o_read_data,
    output logic [ola_pkg::COUNT_W-1:0]   o_count
);

    localparam int CW = $clog2(CAPACITY+1);
    localparam int XW = (CW > ola_pkg::INDEX_W) ? CW : ola_pkg::INDEX_W;

    typedef enum logic {
        S_IDLE,
        S_WAVE
    } t_state;

    t_state                         r_state, n_state;
    logic                           r_valid, n_valid;
    logic [ola_pkg::STS_W-1:0]      r_status, n_status;
    logic [ola_pkg::WORD_W-1:0]     r_data, n_data;
    logic [CW-1:0]                  r_count, n_count;
    logic                           r_launch, n_launch;
    logic                           r_rm, n_rm;
    logic [ola_pkg::WORD_W-1:0]     r_value, n_value;
    logic [ola_pkg::INDEX_W-1:0]    r_index, n_index;
    logic                           wr;

    ola_pkg::t_bcast                bc;
    ola_pkg::t_wave                 wave [CAPACITY+1];
    logic [ola_pkg::WORD_W-1:0]     entry [CAPACITY+1];

    assign busy = (r_state != S_IDLE);

    assign bc.rm    = r_rm;
    assign bc.wr    = wr;
    assign bc.value = (r_state == S_IDLE) ? i_value : r_value;
    assign bc.index = r_index;

    assign wave[0].tok      = r_launch;
    assign wave[0].fnd      = 1'b0;
    assign wave[0].dat      = '0;
    assign entry[CAPACITY]  = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ola_cell #(
            .CAPACITY (CAPACITY),
            .POS      (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_bc         (bc),
            .i_count      (r_count),
            .i_wave       (wave[g]),
            .o_wave       (wave[g+1]),
            .i_next_entry (entry[g+1]),
            .o_entry      (entry[g])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_valid  = 1'b0;
        n_status = r_status;
        n_data   = r_data;
        n_count  = r_count;
        n_launch = 1'b0;
        n_rm     = r_rm;
        n_value  = r_value;
        n_index  = r_index;
        wr       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_cmd)
                        ola_pkg::CMD_APPEND: begin
                            n_valid = 1'b1;
                            n_data  = '0;
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = ola_pkg::STS_FULL;
                            end else begin
                                wr       = 1'b1;
                                n_count  = r_count + CW'(1);
                                n_status = ola_pkg::STS_OK;
                            end
                        end
                        ola_pkg::CMD_READ: begin
                            if (XW'(i_index) >= XW'(r_count)) begin
                                n_valid  = 1'b1;
                                n_status = ola_pkg::STS_RANGE;
                                n_data   = '0;
                            end else begin
                                n_launch = 1'b1;
                                n_rm     = 1'b0;
                                n_index  = i_index;
                                n_state  = S_WAVE;
                            end
                        end
                        ola_pkg::CMD_REMOVE: begin
                            n_launch = 1'b1;
                            n_rm     = 1'b1;
                            n_value  = i_value;
                            n_state  = S_WAVE;
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_status = ola_pkg::STS_OK;
                            n_data   = '0;
                        end
                    endcase
                end
            end
            S_WAVE: begin
                if (wave[CAPACITY].tok) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_data  = wave[CAPACITY].dat;
                    if (r_rm && !wave[CAPACITY].fnd) begin
                        n_status = ola_pkg::STS_NOT_FOUND;
                    end else begin
                        n_status = ola_pkg::STS_OK;
                        if (r_rm) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_data   <= n_data;
        r_rm     <= n_rm;
        r_value  <= n_value;
        r_index  <= n_index;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_count  <= '0;
            r_launch <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_count  <= n_count;
            r_launch <= n_launch;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_read_data = r_data;
    assign o_count     = ola_pkg::COUNT_W'(r_count);

endmodule
`default_nettype wire

// ===== rtl/ola_cell.sv =====
// One cell of the list: holds one entry and forwards the search/read token.
`default_nettype none
module ola_cell #(
    parameter int CAPACITY = ola_pkg::CAPACITY_DEF,
    parameter int POS      = 0
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire ola_pkg::t_bcast                 i_bc,
    input  wire [$clog2(CAPACITY+1)-1:0]         i_count,
    input  wire ola_pkg::t_wave                  i_wave,
    output ola_pkg::t_wave                       o_wave,
    input  wire [ola_pkg::WORD_W-1:0]            i_next_entry,
    output logic [ola_pkg::WORD_W-1:0]           o_entry
);

    localparam int CW = $clog2(CAPACITY+1);
    localparam bit ADDRESSABLE = POS < (1 << ola_pkg::INDEX_W);

    logic [ola_pkg::WORD_W-1:0] r_entry;
    logic [ola_pkg::WORD_W-1:0] n_entry;
    ola_pkg::t_wave             r_wave;
    ola_pkg::t_wave             n_wave;
    logic                       in_list;
    logic                       match;
    logic                       sel;
    logic                       shift;

    assign in_list = CW'(POS) < i_count;
    assign match   = in_list && (r_entry == i_bc.value);
    assign sel     = ADDRESSABLE && (i_bc.index == ola_pkg::INDEX_W'(POS));
    assign shift   = i_wave.tok && i_bc.rm && (i_wave.fnd || match);

    always_comb begin
        n_wave.tok = i_wave.tok;
        n_wave.fnd = i_wave.fnd | (i_bc.rm & match);
        n_wave.dat = (!i_bc.rm && sel) ? r_entry : i_wave.dat;

        n_entry = r_entry;
        if (i_bc.wr && (CW'(POS) == i_count)) begin
            n_entry = i_bc.value;
        end else if (shift) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_wave.tok <= 1'b0;
        end else begin
            r_wave <= n_wave;
        end
    end

    assign o_wave  = r_wave;
    assign o_entry = r_entry;

endmodule
`default_nettype wire
